// ===== rtl/ui_transition_easing_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Transition easing unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef UI_TRANSITION_EASING_UNIT_MACROS_SVH
`define UI_TRANSITION_EASING_UNIT_MACROS_SVH

// Property holds in the same cycle.
`define UTEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UTEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uteu_pkg.sv =====
// ----------------------------------------------------------------------------
// Transition easing unit package
// Field widths, transition modes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package uteu_pkg;

  localparam int unsigned PROGRESS_W = 17;
  localparam int unsigned X_W        = 14;
  localparam int unsigned OPACITY_W  = 8;
  localparam int unsigned SCALE_W    = 17;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned XMUL_W     = 15;
  localparam int unsigned NX_W       = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;

  localparam logic [WIDTH_W-1:0] SCREEN_WIDTH_RST = 12'd480;

  localparam logic signed [NX_W-1:0] X_MAX = 17'sd8191;
  localparam logic signed [NX_W-1:0] X_MIN = -17'sd8192;

  localparam logic [OPACITY_W-1:0] OPACITY_FULL = 8'd255;
  localparam logic [SCALE_W-1:0]   SCALE_UNITY  = 17'd65536;
  localparam logic [XMUL_W-1:0]    SLIDE_SPAN   = 15'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE       = 4'd0,
    MODE_ZOOM_IN    = 4'd1,
    MODE_SCALE_DOWN = 4'd2,
    MODE_SLIDE_IN   = 4'd3,
    MODE_BOUNCE_IN  = 4'd4,
    MODE_COLLAPSE   = 4'd5,
    MODE_SLIDE_OUT  = 4'd7,
    MODE_FADE_ALT   = 4'd8,
    MODE_FADE_IN    = 4'd9,
    MODE_FADE_OUT   = 4'd10
  } mode_e;

  // Piece of the bounce curve that a progress value falls in.
  typedef enum logic [1:0] {
    SEG_RISE    = 2'd0,
    SEG_BOUNCE1 = 2'd1,
    SEG_BOUNCE2 = 2'd2,
    SEG_BOUNCE3 = 2'd3
  } bounce_seg_e;

endpackage

`default_nettype wire

// ===== rtl/uteu_if.sv =====
// ----------------------------------------------------------------------------
// Transition easing unit channels
// Frame input channel and result output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface uteu_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    is_shutdown;
  logic [uteu_pkg::PROGRESS_W-1:0]         progress;
  logic signed [uteu_pkg::X_W-1:0]         current_x;
  logic                                    last_frame;

  modport source (output valid, is_shutdown, progress, current_x, last_frame, input ready);
  modport sink   (input valid, is_shutdown, progress, current_x, last_frame, output ready);
endinterface

interface uteu_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    opacity_valid;
  logic [uteu_pkg::OPACITY_W-1:0]          opacity;
  logic                                    scale_valid;
  logic [uteu_pkg::SCALE_W-1:0]            scale;
  logic                                    move_valid;
  logic signed [uteu_pkg::X_W-1:0]         new_x;
  logic                                    zero_y;
  logic                                    shutdown_now;

  modport source (output valid, opacity_valid, opacity, scale_valid, scale, move_valid,
                  new_x, zero_y, shutdown_now, input ready);
  modport sink   (input valid, opacity_valid, opacity, scale_valid, scale, move_valid,
                  new_x, zero_y, shutdown_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/ui_transition_easing_unit.sv =====
// ----------------------------------------------------------------------------
// Transition easing unit: five-stage pipeline. Throughput one word per cycle
// when not stalled; a stall only holds the stages that are full.
// Reset clears the valid bits and sets the modes to 0 and the width to 480.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ui_transition_easing_unit_macros.svh"

module ui_transition_easing_unit #(
  parameter int unsigned PROGRESS_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [uteu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [uteu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  uteu_in_if.sink                           in_i,
  uteu_out_if.source                        out_o
);

  // Widths of the datapath. The eased value e and the saturated progress t
  // both lie in [0, 1] and need P+1 bits.
  localparam int unsigned P    = PROGRESS_FRAC_BITS;
  localparam int unsigned EW   = P + 1;
  localparam int unsigned CMPW = (EW > uteu_pkg::PROGRESS_W) ? EW : uteu_pkg::PROGRESS_W;
  localparam int unsigned CW   = P + 5;
  localparam int unsigned DW   = P + 7;
  localparam int unsigned UW   = P + 3;
  localparam int unsigned QAW  = P + 2;
  localparam int unsigned QPW  = QAW + EW;
  localparam int unsigned BSW  = 2 * UW;
  localparam int unsigned SW   = P + 2;
  localparam int unsigned OPW  = EW + 8;
  localparam int unsigned XPW  = uteu_pkg::XMUL_W + EW;

  localparam logic [EW-1:0]  ONE      = EW'(1) << P;
  localparam logic [P+2:0]   FOUR_ONE = (P + 3)'(1) << (P + 2);
  localparam logic [CW-1:0]  C4       = CW'(4) << P;
  localparam logic [CW-1:0]  C8       = CW'(8) << P;
  localparam logic [CW-1:0]  C10      = CW'(10) << P;
  localparam logic signed [DW-1:0] O6  = signed'(DW'(6) << P);
  localparam logic signed [DW-1:0] O9  = signed'(DW'(9) << P);
  localparam logic signed [DW-1:0] O21 = signed'(DW'(21) << P);
  localparam logic [SW-1:0]  OFF1     = SW'(3) << (P - 2);
  localparam logic [SW-1:0]  OFF2     = SW'(15) << (P - 4);
  localparam logic [SW-1:0]  OFF3     = SW'(63) << (P - 6);
  localparam logic [SW-1:0]  ONE_S    = SW'(ONE);
  localparam logic [SW-1:0]  TWO_S    = SW'(2) << P;
  localparam logic [SW-1:0]  THREE_S  = SW'(3) << P;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline
  // is empty; the block does not enforce it. Stage 1 samples them directly.
  // --------------------------------------------------------------------------
  logic [uteu_pkg::MODE_W-1:0]  startup_mode_q;
  logic [uteu_pkg::MODE_W-1:0]  shutdown_mode_q;
  logic [uteu_pkg::WIDTH_W-1:0] screen_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_mode_q  <= uteu_pkg::MODE_NONE;
      shutdown_mode_q <= uteu_pkg::MODE_NONE;
      screen_width_q  <= uteu_pkg::SCREEN_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uteu_pkg::CFG_STARTUP_MODE:  startup_mode_q  <= cfg_wdata_i[uteu_pkg::MODE_W-1:0];
        uteu_pkg::CFG_SHUTDOWN_MODE: shutdown_mode_q <= cfg_wdata_i[uteu_pkg::MODE_W-1:0];
        uteu_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[uteu_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the
  // stage after it moves, so bubbles close up and a stall holds every word.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_o.ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: saturate the progress, pick the mode for the direction, and
  // prepare one multiplier operand for each curve. Quadratic ease-in-out is
  // written as a*t with a = 2t on the lower half and a = 4 - 2t above it.
  // Bounce-out works on c = 11t: the rising piece squares c itself, the other
  // pieces the distance to their center (doubled on the last piece).
  // --------------------------------------------------------------------------
  logic [CMPW-1:0]           prog_ext;
  logic [EW-1:0]             t_s1;
  uteu_pkg::mode_e           mode_s1;
  logic                      qlo_s1;
  logic [QAW-1:0]            two_t_s1;
  logic [QAW-1:0]            qa_s1;
  logic [CW-1:0]             c_s1;
  logic signed [DW-1:0]      cx_s1;
  logic signed [DW-1:0]      dist_s1;
  logic [DW-1:0]             dabs_s1;
  uteu_pkg::bounce_seg_e     seg_s1;

  always_comb begin
    prog_ext = CMPW'(in_i.progress);
    t_s1     = (prog_ext > CMPW'(ONE)) ? ONE : prog_ext[EW-1:0];
    mode_s1  = in_i.is_shutdown ? uteu_pkg::mode_e'(shutdown_mode_q)
                                : uteu_pkg::mode_e'(startup_mode_q);
    qlo_s1   = !t_s1[P] && !t_s1[P-1];
    two_t_s1 = {t_s1, 1'b0};
    qa_s1    = qlo_s1 ? two_t_s1 : QAW'(FOUR_ONE - {1'b0, two_t_s1});
    c_s1     = CW'({t_s1, 3'b000}) + CW'({t_s1, 1'b0}) + CW'(t_s1);
    cx_s1    = signed'(DW'(c_s1));
    if (c_s1 < C4) begin
      seg_s1  = uteu_pkg::SEG_RISE;
      dist_s1 = cx_s1;
    end else if (c_s1 < C8) begin
      seg_s1  = uteu_pkg::SEG_BOUNCE1;
      dist_s1 = cx_s1 - O6;
    end else if (c_s1 < C10) begin
      seg_s1  = uteu_pkg::SEG_BOUNCE2;
      dist_s1 = cx_s1 - O9;
    end else begin
      seg_s1  = uteu_pkg::SEG_BOUNCE3;
      dist_s1 = (cx_s1 <<< 1) - O21;
    end
    dabs_s1 = dist_s1[DW-1] ? DW'(-dist_s1) : DW'(dist_s1);
  end

  uteu_pkg::mode_e              mode1_q;
  logic                         qlo1_q;
  logic [QAW-1:0]               qa1_q;
  logic [EW-1:0]                t1_q;
  logic [UW-1:0]                u1_q;
  uteu_pkg::bounce_seg_e        seg1_q;
  logic signed [uteu_pkg::X_W-1:0] cx1_q;
  logic [uteu_pkg::WIDTH_W-1:0] w1_q;
  logic                         last1_q;
  logic                         shut1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      mode1_q <= mode_s1;
      qlo1_q  <= qlo_s1;
      qa1_q   <= qa_s1;
      t1_q    <= t_s1;
      u1_q    <= dabs_s1[UW-1:0];
      seg1_q  <= seg_s1;
      cx1_q   <= in_i.current_x;
      w1_q    <= screen_width_q;
      last1_q <= in_i.last_frame;
      shut1_q <= in_i.is_shutdown;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: one multiplier per curve.
  // --------------------------------------------------------------------------
  uteu_pkg::mode_e              mode2_q;
  logic                         qlo2_q;
  logic [QPW-1:0]               qp2_q;
  logic [BSW-1:0]               bs2_q;
  uteu_pkg::bounce_seg_e        seg2_q;
  logic signed [uteu_pkg::X_W-1:0] cx2_q;
  logic [uteu_pkg::WIDTH_W-1:0] w2_q;
  logic                         last2_q;
  logic                         shut2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      mode2_q <= mode1_q;
      qlo2_q  <= qlo1_q;
      qp2_q   <= QPW'(qa1_q) * QPW'(t1_q);
      bs2_q   <= BSW'(u1_q) * BSW'(u1_q);
      seg2_q  <= seg1_q;
      cx2_q   <= cx1_q;
      w2_q    <= w1_q;
      last2_q <= last1_q;
      shut2_q <= shut1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale the products back to Q.P, add the piece offsets, select
  // the curve for the mode and clamp to one.
  // --------------------------------------------------------------------------
  logic [SW-1:0] qsh_s3;
  logic [SW-1:0] quad_s3;
  logic [SW-1:0] bnc_s3;
  logic [SW-1:0] esel_s3;
  logic [EW-1:0] e_s3;

  always_comb begin
    qsh_s3  = SW'(qp2_q >> P);
    quad_s3 = qlo2_q ? qsh_s3 : qsh_s3 - ONE_S;
    case (seg2_q)
      uteu_pkg::SEG_RISE:    bnc_s3 = SW'(bs2_q >> (P + 4));
      uteu_pkg::SEG_BOUNCE1: bnc_s3 = SW'(bs2_q >> (P + 4)) + OFF1;
      uteu_pkg::SEG_BOUNCE2: bnc_s3 = SW'(bs2_q >> (P + 4)) + OFF2;
      default:               bnc_s3 = SW'(bs2_q >> (P + 6)) + OFF3;
    endcase
    esel_s3 = (mode2_q == uteu_pkg::MODE_BOUNCE_IN) ? bnc_s3 : quad_s3;
    e_s3    = (esel_s3 > ONE_S) ? ONE : esel_s3[EW-1:0];
  end

  uteu_pkg::mode_e              mode3_q;
  logic [EW-1:0]                e3_q;
  logic signed [uteu_pkg::X_W-1:0] cx3_q;
  logic [uteu_pkg::WIDTH_W-1:0] w3_q;
  logic                         last3_q;
  logic                         shut3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      mode3_q <= mode2_q;
      e3_q    <= e_s3;
      cx3_q   <= cx2_q;
      w3_q    <= w2_q;
      last3_q <= last2_q;
      shut3_q <= shut2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: the effect products. Opacity uses e or 1 - e times 255. The
  // position needs one product of e with 100, with the width, or with the
  // distance to the right edge, depending on the mode, so one multiplier
  // serves all three. The scale numerator is an add or a subtract in Q.P.
  // --------------------------------------------------------------------------
  logic                          fade_out_s4;
  logic [EW-1:0]                 fe_s4;
  logic [SW-1:0]                 num_s4;
  logic signed [15:0]            d_s4;
  logic [uteu_pkg::XMUL_W-1:0]   mag_s4;
  logic [uteu_pkg::XMUL_W-1:0]   xm_s4;

  always_comb begin
    d_s4   = $signed({4'b0000, w3_q}) - 16'(cx3_q);
    mag_s4 = d_s4[15] ? 15'(-d_s4) : 15'(d_s4);
    fade_out_s4 = 1'b0;
    num_s4      = '0;
    xm_s4       = '0;
    unique case (mode3_q) inside
      uteu_pkg::MODE_ZOOM_IN: begin
        num_s4 = ONE_S + SW'(e3_q);
      end
      uteu_pkg::MODE_SCALE_DOWN: begin
        num_s4 = THREE_S - SW'(e3_q);
        xm_s4  = uteu_pkg::SLIDE_SPAN;
      end
      uteu_pkg::MODE_SLIDE_IN, uteu_pkg::MODE_BOUNCE_IN: begin
        xm_s4 = uteu_pkg::XMUL_W'(w3_q);
      end
      uteu_pkg::MODE_COLLAPSE: begin
        num_s4      = TWO_S - SW'(e3_q);
        fade_out_s4 = 1'b1;
      end
      uteu_pkg::MODE_SLIDE_OUT: begin
        xm_s4       = mag_s4;
        fade_out_s4 = 1'b1;
      end
      uteu_pkg::MODE_FADE_OUT: begin
        fade_out_s4 = 1'b1;
      end
      default: ;
    endcase
    fe_s4 = fade_out_s4 ? ONE - e3_q : e3_q;
  end

  uteu_pkg::mode_e              mode4_q;
  logic [OPW-1:0]               op4_q;
  logic [SW-1:0]                num4_q;
  logic [XPW-1:0]               xp4_q;
  logic                         dneg4_q;
  logic signed [uteu_pkg::X_W-1:0] cx4_q;
  logic [uteu_pkg::WIDTH_W-1:0] w4_q;
  logic                         last4_q;
  logic                         shut4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      mode4_q <= mode3_q;
      op4_q   <= {fe_s4, 8'h00} - OPW'(fe_s4);
      num4_q  <= num_s4;
      xp4_q   <= XPW'(xm_s4) * XPW'(e3_q);
      dneg4_q <= d_s4[15];
      cx4_q   <= cx3_q;
      w4_q    <= w3_q;
      last4_q <= last3_q;
      shut4_q <= shut3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: finish the fields, apply the end-of-animation rule and saturate
  // the position. This stage is the output register.
  // --------------------------------------------------------------------------
  logic [uteu_pkg::OPACITY_W-1:0] opv_s5;
  logic [uteu_pkg::SCALE_W-1:0]   scv_s5;
  logic [uteu_pkg::XMUL_W-1:0]    m_s5;
  logic signed [uteu_pkg::NX_W-1:0] ms_s5;
  logic signed [uteu_pkg::NX_W-1:0] nx_s5;
  logic signed [uteu_pkg::NX_W-1:0] nxs_s5;
  logic                           ov_s5, sv_s5, mv_s5, zy_s5, sd_s5;
  logic [uteu_pkg::OPACITY_W-1:0] op_s5;
  logic [uteu_pkg::SCALE_W-1:0]   sc_s5;

  always_comb begin
    opv_s5 = uteu_pkg::OPACITY_W'(op4_q >> P);
    scv_s5 = uteu_pkg::SCALE_W'({num4_q, 16'h0000} >> (P + 1));
    m_s5   = uteu_pkg::XMUL_W'(xp4_q >> P);
    ms_s5  = $signed({2'b00, m_s5});
    ov_s5  = 1'b0;
    op_s5  = '0;
    sv_s5  = 1'b0;
    sc_s5  = '0;
    mv_s5  = 1'b0;
    nx_s5  = '0;
    zy_s5  = 1'b0;
    sd_s5  = 1'b0;
    unique case (mode4_q) inside
      uteu_pkg::MODE_ZOOM_IN: begin
        sv_s5 = 1'b1;
        sc_s5 = scv_s5;
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
      end
      uteu_pkg::MODE_SCALE_DOWN: begin
        sv_s5 = 1'b1;
        sc_s5 = scv_s5;
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
        mv_s5 = 1'b1;
        nx_s5 = $signed({2'b00, uteu_pkg::SLIDE_SPAN}) - ms_s5;
      end
      uteu_pkg::MODE_SLIDE_IN, uteu_pkg::MODE_BOUNCE_IN: begin
        mv_s5 = 1'b1;
        nx_s5 = $signed({5'b00000, w4_q}) - ms_s5;
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
        sv_s5 = 1'b1;
        sc_s5 = uteu_pkg::SCALE_UNITY;
      end
      uteu_pkg::MODE_COLLAPSE: begin
        sv_s5 = 1'b1;
        sc_s5 = scv_s5;
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
      end
      uteu_pkg::MODE_SLIDE_OUT: begin
        mv_s5 = 1'b1;
        nx_s5 = 17'(cx4_q) + (dneg4_q ? -ms_s5 : ms_s5);
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
        sv_s5 = 1'b1;
        sc_s5 = uteu_pkg::SCALE_UNITY;
      end
      uteu_pkg::MODE_FADE_ALT, uteu_pkg::MODE_FADE_IN, uteu_pkg::MODE_FADE_OUT: begin
        ov_s5 = 1'b1;
        op_s5 = opv_s5;
      end
      default: ;
    endcase

    // Mode zero only asks for shutdown. Otherwise the last frame of a
    // startup resets the window, and that of a shutdown asks for close.
    if (mode4_q == uteu_pkg::MODE_NONE) begin
      sd_s5 = 1'b1;
    end else if (last4_q) begin
      if (shut4_q) begin
        sd_s5 = 1'b1;
      end else begin
        sv_s5 = 1'b1;
        sc_s5 = '0;
        ov_s5 = 1'b1;
        op_s5 = uteu_pkg::OPACITY_FULL;
        mv_s5 = 1'b1;
        nx_s5 = '0;
        zy_s5 = 1'b1;
      end
    end

    if (nx_s5 > uteu_pkg::X_MAX) begin
      nxs_s5 = uteu_pkg::X_MAX;
    end else if (nx_s5 < uteu_pkg::X_MIN) begin
      nxs_s5 = uteu_pkg::X_MIN;
    end else begin
      nxs_s5 = nx_s5;
    end
  end

  logic                            ov5_q, sv5_q, mv5_q, zy5_q, sd5_q;
  logic [uteu_pkg::OPACITY_W-1:0]  op5_q;
  logic [uteu_pkg::SCALE_W-1:0]    sc5_q;
  logic signed [uteu_pkg::X_W-1:0] nx5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      ov5_q <= ov_s5;
      op5_q <= op_s5;
      sv5_q <= sv_s5;
      sc5_q <= sc_s5;
      mv5_q <= mv_s5;
      nx5_q <= nxs_s5[uteu_pkg::X_W-1:0];
      zy5_q <= zy_s5;
      sd5_q <= sd_s5;
    end
  end

  assign out_o.valid         = v5_q;
  assign out_o.opacity_valid = ov5_q;
  assign out_o.opacity       = op5_q;
  assign out_o.scale_valid   = sv5_q;
  assign out_o.scale         = sc5_q;
  assign out_o.move_valid    = mv5_q;
  assign out_o.new_x         = nx5_q;
  assign out_o.zero_y        = zy5_q;
  assign out_o.shutdown_now  = sd5_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The startup end reset always writes scale, opacity and position together.
  `UTEU_ASSERT(a_end_reset, !(out_o.valid && out_o.zero_y) || (out_o.move_valid && out_o.new_x == '0 && out_o.scale_valid && out_o.scale == '0 && out_o.opacity == uteu_pkg::OPACITY_FULL), "startup end reset incomplete")
  // A field that is not written reads as zero.
  `UTEU_ASSERT(a_unused_zero, !(out_o.valid && !out_o.opacity_valid) || (out_o.opacity == '0 && !out_o.zero_y), "unwritten opacity not zero")
  // Every accepted word lands in the first stage.
  `UTEU_ASSERT_NEXT(a_accept_lands, in_i.valid && in_i.ready, v1_q, "accepted word lost at entry")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Transition easing unit testbench
// Drives animation frames through the unit under several mode and width
// settings, predicts each result word and checks every field of it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROGRESS_W = uteu_pkg::PROGRESS_W;
  localparam int unsigned X_W        = uteu_pkg::X_W;
  localparam int unsigned OPACITY_W  = uteu_pkg::OPACITY_W;
  localparam int unsigned SCALE_W    = uteu_pkg::SCALE_W;
  localparam int unsigned MODE_W     = uteu_pkg::MODE_W;
  localparam int unsigned WIDTH_W    = uteu_pkg::WIDTH_W;
  localparam int unsigned CFG_IDX_W  = uteu_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = uteu_pkg::CFG_DATA_W;

  localparam int CLK_PERIOD  = 8;
  localparam int FRAC        = 16;          // progress fraction bits
  localparam int SCALE_FRAC  = 16;          // scale is always Q.16
  localparam int Q_ONE       = 1 << FRAC;
  localparam int IDLE_SETTLE = 8;           // settle time after the unit drains
  localparam int HOLD_CYCLES = 150;         // long receiver hold-off
  localparam int PHASE_ITEMS = 120;
  localparam int NUM_PHASES  = 16;

  // One input word: an animation frame.
  typedef struct {
    logic                  shut;
    logic [PROGRESS_W-1:0] progress;
    logic signed [X_W-1:0] cur_x;
    logic                  last_f;
  } frame_t;

  // One output word: what the window should do this frame.
  typedef struct {
    logic                  opacity_valid;
    logic [OPACITY_W-1:0]  opacity;
    logic                  scale_valid;
    logic [SCALE_W-1:0]    scale;
    logic                  move_valid;
    logic signed [X_W-1:0] new_x;
    logic                  zero_y;
    logic                  shutdown_now;
  } frame_effect_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  uteu_in_if  in_if ();
  uteu_out_if out_if ();

  ui_transition_easing_unit #(
    .PROGRESS_FRAC_BITS(FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Our copy of the configuration registers. They only change while the
  // unit is empty, so the copy can be used at the moment a frame is taken.
  logic [MODE_W-1:0]  startup_mode_q;
  logic [MODE_W-1:0]  shutdown_mode_q;
  logic [WIDTH_W-1:0] width_q;

  frame_t        frame_q[$];     // frames waiting to be offered
  frame_effect_t effect_q[$];    // predicted results, oldest first

  int unsigned offered_cnt = 0;  // frames put on the input channel
  int unsigned taken_cnt   = 0;  // frames the unit has accepted
  int unsigned mismatches  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        rx_hold = 1'b0;
  event        rx_hold_req;

  // --------------------------------------------------------------------------
  // Easing curves, all in Q.FRAC and truncated like the hardware.
  // --------------------------------------------------------------------------

  // Quadratic ease-in-out: 2t^2 in the first half, (4 - 2t)t - 1 after it.
  function automatic longint quad_ease(longint t);
    if (2 * t < Q_ONE) return (2 * t * t) >> FRAC;
    return (((4 * Q_ONE - 2 * t) * t) >> FRAC) - Q_ONE;
  endfunction

  // Bounce-out, split into its four arcs on c = 11t.
  function automatic longint bounce_ease(longint t);
    longint c, u, r;
    c = 11 * t;
    if (c < 4 * Q_ONE) begin
      r = (c * c) >> (FRAC + 4);
    end else if (c < 8 * Q_ONE) begin
      u = c - 6 * Q_ONE;
      r = ((u * u) >> (FRAC + 4)) + (3 * Q_ONE) / 4;
    end else if (c < 10 * Q_ONE) begin
      u = c - 9 * Q_ONE;
      r = ((u * u) >> (FRAC + 4)) + (15 * Q_ONE) / 16;
    end else begin
      u = 2 * c - 21 * Q_ONE;
      r = ((u * u) >> (FRAC + 6)) + (63 * Q_ONE) / 64;
    end
    return (r > Q_ONE) ? longint'(Q_ONE) : r;
  endfunction

  // Takes a value in Q.(FRAC+1), which is a halved Q.FRAC value, to Q.16.
  function automatic longint halve_to_scale(longint num);
    return (num << SCALE_FRAC) >> (FRAC + 1);
  endfunction

  // Works out what the unit must produce for one frame.
  function automatic frame_effect_t predict_effect(logic shut, logic [PROGRESS_W-1:0] prog,
                                                   logic signed [X_W-1:0] cur_x,
                                                   logic last_f);
    frame_effect_t r;
    logic [MODE_W-1:0] md;
    longint t, e, fade_in, fade_out, w, cx, d, mag, m, nx, sc;
    r  = '{default: '0};
    md = shut ? shutdown_mode_q : startup_mode_q;
    w  = longint'(width_q);
    cx = longint'(cur_x);
    nx = 0;
    sc = 0;
    // Progress past one saturates before easing.
    t = longint'(prog);
    if (t > Q_ONE) t = longint'(Q_ONE);
    e = (md == uteu_pkg::MODE_BOUNCE_IN) ? bounce_ease(t) : quad_ease(t);
    if (e > Q_ONE) e = longint'(Q_ONE);

    if (md == uteu_pkg::MODE_NONE) begin
      // No transition at all: only ask for shutdown, the end rule is skipped.
      r.shutdown_now = 1'b1;
    end else begin
      fade_in  = (longint'(uteu_pkg::OPACITY_FULL) * e) >> FRAC;
      fade_out = (longint'(uteu_pkg::OPACITY_FULL) * (Q_ONE - e)) >> FRAC;
      case (md)
        uteu_pkg::MODE_ZOOM_IN: begin
          r.scale_valid = 1'b1; sc = halve_to_scale(Q_ONE + e);
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_in);
        end
        uteu_pkg::MODE_SCALE_DOWN: begin
          r.scale_valid = 1'b1; sc = halve_to_scale(3 * Q_ONE - e);
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_in);
          r.move_valid = 1'b1;
          nx = longint'(uteu_pkg::SLIDE_SPAN)
             - ((longint'(uteu_pkg::SLIDE_SPAN) * e) >> FRAC);
        end
        uteu_pkg::MODE_SLIDE_IN, uteu_pkg::MODE_BOUNCE_IN: begin
          r.move_valid = 1'b1; nx = w - ((w * e) >> FRAC);
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_in);
          r.scale_valid = 1'b1; sc = longint'(uteu_pkg::SCALE_UNITY);
        end
        uteu_pkg::MODE_COLLAPSE: begin
          r.scale_valid = 1'b1; sc = halve_to_scale(2 * Q_ONE - e);
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_out);
        end
        uteu_pkg::MODE_SLIDE_OUT: begin
          // Move from cx toward the right edge; the distance is scaled by
          // magnitude so that truncation goes toward zero either way.
          d   = w - cx;
          mag = (d < 0) ? -d : d;
          m   = (mag * e) >> FRAC;
          r.move_valid = 1'b1; nx = cx + ((d < 0) ? -m : m);
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_out);
          r.scale_valid = 1'b1; sc = longint'(uteu_pkg::SCALE_UNITY);
        end
        uteu_pkg::MODE_FADE_ALT, uteu_pkg::MODE_FADE_IN: begin
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_in);
        end
        uteu_pkg::MODE_FADE_OUT: begin
          r.opacity_valid = 1'b1; r.opacity = OPACITY_W'(fade_out);
        end
        default: ;  // the unused modes write nothing but keep the end rule
      endcase
      if (last_f) begin
        if (shut) begin
          r.shutdown_now = 1'b1;
        end else begin
          // Startup end puts the window back in its resting place.
          r.scale_valid = 1'b1; sc = 0;
          r.opacity_valid = 1'b1; r.opacity = uteu_pkg::OPACITY_FULL;
          r.move_valid = 1'b1; nx = 0; r.zero_y = 1'b1;
        end
      end
    end
    if (nx < longint'(uteu_pkg::X_MIN)) nx = longint'(uteu_pkg::X_MIN);
    if (nx > longint'(uteu_pkg::X_MAX)) nx = longint'(uteu_pkg::X_MAX);
    r.new_x = X_W'(nx);
    r.scale = SCALE_W'(sc);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  function automatic void push_frame(logic shut, logic [PROGRESS_W-1:0] prog,
                                     logic signed [X_W-1:0] cur_x, logic last_f);
    frame_t f;
    f.shut     = shut;
    f.progress = prog;
    f.cur_x    = cur_x;
    f.last_f   = last_f;
    frame_q.push_back(f);
  endfunction

  // A whole animation: rising progress, one direction, ending on the last
  // frame. One in ten never flags its end, which the unit must not care about.
  function automatic int queue_animation();
    int unsigned frames;
    logic shut;
    logic broken;
    logic signed [X_W-1:0] x;
    logic [PROGRESS_W-1:0] p;
    frames = $urandom_range(12, 2);
    shut   = 1'($urandom_range(1));
    broken = ($urandom_range(9) == 0);
    x      = X_W'($urandom);
    for (int i = 1; i <= frames; i++) begin
      if (i < frames) p = PROGRESS_W'((Q_ONE * i) / frames + $urandom_range(255));
      else if ($urandom_range(3) == 0) p = PROGRESS_W'(Q_ONE + $urandom_range(Q_ONE - 1));
      else p = PROGRESS_W'(Q_ONE);
      push_frame(shut, p, x, (i == frames) && !broken);
      x = x + X_W'($urandom_range(64)) - X_W'(32);
    end
    return frames;
  endfunction

  // A single frame with no relation to its neighbors.
  function automatic void queue_noise();
    logic [PROGRESS_W-1:0] p;
    case ($urandom_range(3))
      0:       p = PROGRESS_W'($urandom);
      1:       p = ($urandom_range(1) == 1) ? '1 : '0;
      default: p = PROGRESS_W'($urandom_range(Q_ONE));
    endcase
    push_frame(1'($urandom_range(1)), p, X_W'($urandom), 1'($urandom_range(1)));
  endfunction

  // Waits until every queued frame has been taken and every result has come
  // back, then lets the pipeline settle.
  task automatic wait_idle();
    while (frame_q.size() != 0 || offered_cnt != taken_cnt || effect_q.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  // Writes all three registers, one per cycle, with the unit empty.
  task automatic write_settings(logic [MODE_W-1:0] su, logic [MODE_W-1:0] sd,
                                logic [WIDTH_W-1:0] w);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= uteu_pkg::CFG_STARTUP_MODE;
    cfg_wdata_i <= CFG_DATA_W'(su);
    @(negedge clk_i);
    cfg_idx_i   <= uteu_pkg::CFG_SHUTDOWN_MODE;
    cfg_wdata_i <= CFG_DATA_W'(sd);
    @(negedge clk_i);
    cfg_idx_i   <= uteu_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    startup_mode_q  = su;
    shutdown_mode_q = sd;
    width_q         = w;
  endtask

  // --------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A word stays on the channel
  // until it is taken; the next one may follow without a gap.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : frame_driver
    frame_t f;
    out_if.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
    if (rst_ni && offered_cnt == taken_cnt) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        f = frame_q[0];
        in_if.valid       <= 1'b1;
        in_if.is_shutdown <= f.shut;
        in_if.progress    <= f.progress;
        in_if.current_x   <= f.cur_x;
        in_if.last_frame  <= f.last_f;
        offered_cnt++;
      end else begin
        // Idle cycle: scramble the payload, the unit must ignore it.
        in_if.valid       <= 1'b0;
        in_if.is_shutdown <= 1'($urandom);
        in_if.progress    <= PROGRESS_W'($urandom);
        in_if.current_x   <= X_W'($urandom);
        in_if.last_frame  <= 1'($urandom);
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing and the
  // pipeline fills and pushes back on its input.
  always begin : rx_hold_off
    @(rx_hold_req);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic void check_field(string name, logic signed [17:0] want,
                                      logic signed [17:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Results are checked
  // against the oldest prediction; accepted frames get their prediction here.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    frame_effect_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (effect_q.size() == 0) begin
        $display("%0t: result word with no frame pending", $time);
        mismatches++;
      end else begin
        want = effect_q.pop_front();
        check_field("opacity_valid", 18'(want.opacity_valid), 18'(out_if.opacity_valid));
        check_field("opacity",       18'(want.opacity),       18'(out_if.opacity));
        check_field("scale_valid",   18'(want.scale_valid),   18'(out_if.scale_valid));
        check_field("scale",         18'(want.scale),         18'(out_if.scale));
        check_field("move_valid",    18'(want.move_valid),    18'(out_if.move_valid));
        check_field("new_x",         18'(want.new_x),         18'(out_if.new_x));
        check_field("zero_y",        18'(want.zero_y),        18'(out_if.zero_y));
        check_field("shutdown_now",  18'(want.shutdown_now),  18'(out_if.shutdown_now));
      end
    end
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      effect_q.push_back(predict_effect(in_if.is_shutdown, in_if.progress,
                                        in_if.current_x, in_if.last_frame));
      void'(frame_q.pop_front());
      taken_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned queued;
    logic [WIDTH_W-1:0] w;
    int unsigned dir_width [8];
    dir_width = '{0, 4095, 1, 480, 4095, 0, 1234, 1};

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = uteu_pkg::CFG_STARTUP_MODE;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.is_shutdown = 1'b0;
    in_if.progress    = '0;
    in_if.current_x   = '0;
    in_if.last_frame  = 1'b0;
    out_if.ready      = 1'b0;
    startup_mode_q    = '0;
    shutdown_mode_q   = '0;
    width_q           = uteu_pkg::SCREEN_WIDTH_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: each mode value appears once, even ones as the startup
    // mode and odd ones as the shutdown mode. Each setting sees zero progress
    // at the far left, progress well past one at the far right on a shutdown
    // end frame, and the midpoint of the curve on a startup end frame. Mode
    // zero with an end frame shows that the end rule is skipped there.
    for (int k = 0; k < 8; k++) begin
      write_settings(MODE_W'(2 * k), MODE_W'(2 * k + 1), WIDTH_W'(dir_width[k]));
      push_frame(1'b0, '0, X_W'(uteu_pkg::X_MIN), 1'b0);
      push_frame(1'b1, '1, X_W'(uteu_pkg::X_MAX), 1'b1);
      push_frame(1'b0, PROGRESS_W'(Q_ONE / 2), '0, 1'b1);
    end

    // Random part: each phase picks new modes for both directions and a
    // width, with the extremes of the width in turn. Idling rotates through
    // none, sender only, receiver only, and both.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 5)
        0:       w = '1;
        1:       w = WIDTH_W'(1);
        2:       w = '0;
        3:       w = uteu_pkg::SCREEN_WIDTH_RST;
        default: w = WIDTH_W'($urandom_range(4095, 1));
      endcase
      // Settings are written with the unit drained, so the sender pauses
      // here until every result of the last phase has come back.
      write_settings(MODE_W'(p), MODE_W'((7 * p + 3) % 16), w);
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 61; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 61; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
      if (p == 6) begin
        // Back-pressure check: receiver shut for a long time, sender flat out.
        src_idle_pct = 0;
        -> rx_hold_req;
      end
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          queued += queue_animation();
        end else begin
          queue_noise();
          queued++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : run_limit
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== ui_transition_easing_unit.f =====
+incdir+rtl
rtl/uteu_pkg.sv
rtl/uteu_if.sv
rtl/ui_transition_easing_unit.sv
tb/tb_top.sv
